FILE: rtl/core/tfl_pkg.sv
// Shared constants, types and helper functions for the background line fetch block.
package tfl_pkg;

   // Line geometry
   localparam int LINE_PIXELS = 160;
   localparam int GROUPS      = LINE_PIXELS / 8;
   localparam int GROUP_W     = 5;
   localparam int TOTAL_LINES = 154;
   localparam int VBLANK_LINE = 144;
   localparam int LINE_W      = 8;

   // Video store
   localparam int STORE_DEPTH = 8192;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam logic [STORE_AW-1:0] MAP_LOW_BASE  = STORE_AW'(16'h1800);
   localparam logic [STORE_AW-1:0] MAP_HIGH_BASE = STORE_AW'(16'h1C00);
   localparam logic [STORE_AW-1:0] SIGNED_BASE   = STORE_AW'(16'h1000);

   // Front/back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Register port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;
   localparam logic [1:0] CSR_SCROLL_Y    = 2'd0;
   localparam logic [1:0] CSR_MAP_SELECT  = 2'd1;
   localparam logic [1:0] CSR_DATA_SELECT = 2'd2;

   // Input commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   typedef enum logic [1:0] {
      KIND_WRITE,
      KIND_VBLANK,
      KIND_LINE
   } item_kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LO,
      ST_HI,
      ST_PIX
   } back_state_type;

   typedef struct packed {
      logic [7:0] scroll_y;
      logic       map_select;
      logic       data_select;
   } cfg_type;

   typedef struct packed {
      item_kind_type       kind;
      logic [LINE_W-1:0]   line;
      logic [7:0]          y;
      logic                map_sel;
      logic                data_sel;
      logic [STORE_AW-1:0] addr;
      logic [7:0]          data;
   } queue_entry_type;

   // Tile map entry address for a scrolled line and a pixel group
   function automatic logic [STORE_AW-1:0] map_addr(input logic map_sel,
                                                    input logic [7:0] y,
                                                    input logic [GROUP_W-1:0] group);
      logic [STORE_AW-1:0] base;
      base = map_sel ? MAP_HIGH_BASE : MAP_LOW_BASE;
      return base + STORE_AW'({y[7:3], group});
   endfunction

   // Low-plane byte address of a tile row; tile is unsigned or signed around 0x1000
   function automatic logic [STORE_AW-1:0] tile_addr(input logic data_sel,
                                                     input logic [7:0] tile,
                                                     input logic [2:0] row);
      logic [STORE_AW-1:0] base;
      if (data_sel) begin
         base = STORE_AW'({tile, 4'b0000});
      end else begin
         base = SIGNED_BASE + STORE_AW'({{(STORE_AW-12){tile[7]}}, tile, 4'b0000});
      end
      return base + STORE_AW'({row, 1'b0});
   endfunction

   // Interleave the two bit planes, leftmost pixel in the top two bits
   function automatic logic [15:0] interleave(input logic [7:0] lo, input logic [7:0] hi);
      logic [15:0] pix;
      for (int k = 0; k < 8; k++) begin
         pix[2*k+1] = hi[k];
         pix[2*k]   = lo[k];
      end
      return pix;
   endfunction

endpackage

FILE: rtl/core/tfl_req_if.sv
// Input item channel: store writes and line ticks.
interface tfl_req_if;
   logic                         valid;
   logic                         ready;
   logic                         cmd;
   logic [tfl_pkg::STORE_AW-1:0] store_addr;
   logic [7:0]                   store_data;

   modport source (output valid, cmd, store_addr, store_data, input ready);
   modport sink (input valid, cmd, store_addr, store_data, output ready);
endinterface

FILE: rtl/core/tfl_rsp_if.sv
// Result item channel: pixel groups and the vertical blank request.
interface tfl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        vblank_irq;
   logic [tfl_pkg::LINE_W-1:0]  line_number;
   logic [tfl_pkg::GROUP_W-1:0] group_index;
   logic [15:0]                 pixels;
   logic                        last;

   modport source (output valid, vblank_irq, line_number, group_index, pixels, last,
                   input ready);
   modport sink (input valid, vblank_irq, line_number, group_index, pixels, last,
                 output ready);
endinterface

FILE: rtl/core/tile_background_line_fetch.sv
// Top level of the background tile line fetch block.
//
// Input channel req_ch carries store writes (cmd 0: store_addr, store_data)
// and line ticks (cmd 1). Results leave on rsp_ch: one vertical blank item
// when the line counter reaches 144, and 20 pixel-group items (last set on
// the final one) for each visible line 0..143; lines 145..153 give none.
// scroll_y, map_select and data_select sit at byte addresses 0, 4 and 8 of
// the csr_ port and are sampled when a tick is accepted.
// With the fetch engine idle, a write passes through the queue and is then
// written to the store, and a vertical blank item passes from the queue to
// the result register. Each group of a visible line needs a map read, a
// low-plane read and a high-plane read on the single store read port, so a
// visible line holds the engine until its last group is loaded.
// A four-entry queue separates the front end from the fetch engine, so
// items keep being accepted while a result waits on a stalled receiver,
// until the queue is full; then req_ch.ready drops.
// After reset the 8192-byte store is cleared, one byte a cycle; no item is
// accepted then, register writes still are.
module tile_background_line_fetch (
   input  logic                       clock,
   input  logic                       reset,
   tfl_req_if.sink                    req_ch,
   tfl_rsp_if.source                  rsp_ch,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [tfl_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [tfl_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [tfl_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);

   tfl_pkg::cfg_type          cfg;
   tfl_pkg::queue_entry_type  push_entry, head;
   logic                      q_push, q_full, q_pop, head_valid, clear_busy;

   tfl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tfl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .cfg        (cfg),
      .clear_busy (clear_busy),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry)
   );

   tfl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (head),
      .head_valid (head_valid)
   );

   tfl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (q_pop),
      .clear_busy (clear_busy),
      .rsp        (rsp_ch)
   );

endmodule

FILE: rtl/core/tfl_csr.sv
// Configuration registers behind the APB-style port.
module tfl_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [tfl_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [tfl_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [tfl_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready,
   output tfl_pkg::cfg_type           cfg
);

   tfl_pkg::cfg_type cfg_ff, cfg_in;
   logic [1:0]       index;
   logic             wr_en;

   assign index      = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Register writes; addresses past the list are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            tfl_pkg::CSR_SCROLL_Y:    cfg_in.scroll_y    = csr_pwdata[7:0];
            tfl_pkg::CSR_MAP_SELECT:  cfg_in.map_select  = csr_pwdata[0];
            tfl_pkg::CSR_DATA_SELECT: cfg_in.data_select = csr_pwdata[0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scroll_y    <= 8'd0;
         cfg_ff.map_select  <= 1'b0;
         cfg_ff.data_select <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      case (index)
         tfl_pkg::CSR_SCROLL_Y:    csr_prdata = tfl_pkg::CSR_DW'(cfg_ff.scroll_y);
         tfl_pkg::CSR_MAP_SELECT:  csr_prdata = tfl_pkg::CSR_DW'(cfg_ff.map_select);
         tfl_pkg::CSR_DATA_SELECT: csr_prdata = tfl_pkg::CSR_DW'(cfg_ff.data_select);
         default:                  csr_prdata = '0;
      endcase
   end

endmodule

FILE: rtl/core/tfl_front.sv
// Front end: accepts items, tracks the line counter and classifies each item.
module tfl_front (
   input  logic                      clock,
   input  logic                      reset,
   tfl_req_if.sink                   req,
   input  tfl_pkg::cfg_type          cfg,
   input  logic                      clear_busy,
   input  logic                      q_full,
   output logic                      q_push,
   output tfl_pkg::queue_entry_type  q_entry
);

   logic [tfl_pkg::LINE_W-1:0] line_ff, line_in, line_next;
   logic                       accept;

   assign req.ready = !clear_busy && !q_full;
   assign accept    = req.valid && req.ready;

   // Line counter wraps after the last line of the frame
   assign line_next = (line_ff == tfl_pkg::LINE_W'(tfl_pkg::TOTAL_LINES - 1))
                      ? '0 : line_ff + 1'b1;
   assign line_in   = (accept && req.cmd == tfl_pkg::CMD_TICK) ? line_next : line_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= '0;
      end else begin
         line_ff <= line_in;
      end
   end

   // Classify; lines past vertical blank carry no work and are dropped
   always_comb begin
      q_entry.line     = line_next;
      q_entry.y        = line_next + cfg.scroll_y;
      q_entry.map_sel  = cfg.map_select;
      q_entry.data_sel = cfg.data_select;
      q_entry.addr     = req.store_addr;
      q_entry.data     = req.store_data;
      q_entry.kind     = tfl_pkg::KIND_WRITE;
      q_push           = accept;
      if (req.cmd == tfl_pkg::CMD_TICK) begin
         if (line_next == tfl_pkg::LINE_W'(tfl_pkg::VBLANK_LINE)) begin
            q_entry.kind = tfl_pkg::KIND_VBLANK;
         end else if (line_next < tfl_pkg::LINE_W'(tfl_pkg::VBLANK_LINE)) begin
            q_entry.kind = tfl_pkg::KIND_LINE;
         end else begin
            q_push = 1'b0;
         end
      end
   end

endmodule

FILE: rtl/core/tfl_queue.sv
// Short FIFO between the front end and the fetch engine.
module tfl_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tfl_pkg::queue_entry_type  push_entry,
   output logic                      full,
   input  logic                      pop,
   output tfl_pkg::queue_entry_type  head,
   output logic                      head_valid
);

   tfl_pkg::queue_entry_type        entries_ff [tfl_pkg::QUEUE_DEPTH];
   logic [tfl_pkg::QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [tfl_pkg::QUEUE_AW:0]      count_ff, count_in;
   logic                            do_push, do_pop;

   assign full       = (count_ff == (tfl_pkg::QUEUE_AW+1)'(tfl_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/core/tfl_back.sv
// Fetch engine: owns the video store, clears it, applies writes and fetches pixel groups.
module tfl_back (
   input  logic                      clock,
   input  logic                      reset,
   input  tfl_pkg::queue_entry_type  head,
   input  logic                      head_valid,
   output logic                      pop,
   output logic                      clear_busy,
   tfl_rsp_if.source                 rsp
);

   localparam logic [tfl_pkg::STORE_AW-1:0] LAST_ADDR =
      tfl_pkg::STORE_AW'(tfl_pkg::STORE_DEPTH - 1);
   localparam logic [tfl_pkg::GROUP_W-1:0] LAST_GROUP =
      tfl_pkg::GROUP_W'(tfl_pkg::GROUPS - 1);

   logic [7:0] video_mem [tfl_pkg::STORE_DEPTH];

   tfl_pkg::back_state_type        state_ff, state_in;
   logic [tfl_pkg::STORE_AW-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [tfl_pkg::GROUP_W-1:0]    group_ff, group_in;
   logic [tfl_pkg::LINE_W-1:0]     line_ff, line_in;
   logic [7:0]                     y_ff, y_in;
   logic                           map_sel_ff, map_sel_in;
   logic                           data_sel_ff, data_sel_in;
   logic [tfl_pkg::STORE_AW-1:0]   ta_ff, ta_in;
   logic [7:0]                     lo_ff, lo_in;
   logic [7:0]                     rd_data_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           irq_ff, irq_in;
   logic [tfl_pkg::LINE_W-1:0]     rline_ff, rline_in;
   logic [tfl_pkg::GROUP_W-1:0]    rgroup_ff, rgroup_in;
   logic [15:0]                    pix_ff, pix_in;
   logic                           rlast_ff, rlast_in;

   logic                           out_free, load_out, last_group;
   logic                           wr_en;
   logic [tfl_pkg::STORE_AW-1:0]   wr_addr, rd_addr;
   logic [7:0]                     wr_data;

   assign out_free    = !rsp_valid_ff || rsp.ready;
   assign last_group  = (group_ff == LAST_GROUP);
   assign clear_busy  = (state_ff == tfl_pkg::ST_CLEAR);

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.vblank_irq  = irq_ff;
   assign rsp.line_number = rline_ff;
   assign rsp.group_index = rgroup_ff;
   assign rsp.pixels      = pix_ff;
   assign rsp.last        = rlast_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tfl_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == LAST_ADDR) state_in = tfl_pkg::ST_IDLE;
         end
         tfl_pkg::ST_IDLE: begin
            if (head_valid && head.kind == tfl_pkg::KIND_LINE) state_in = tfl_pkg::ST_LO;
         end
         tfl_pkg::ST_LO:  state_in = tfl_pkg::ST_HI;
         tfl_pkg::ST_HI:  state_in = tfl_pkg::ST_PIX;
         tfl_pkg::ST_PIX: begin
            if (out_free) state_in = last_group ? tfl_pkg::ST_IDLE : tfl_pkg::ST_LO;
         end
         default: state_in = tfl_pkg::ST_IDLE;
      endcase
   end

   // Datapath control per state
   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      group_in    = group_ff;
      line_in     = line_ff;
      y_in        = y_ff;
      map_sel_in  = map_sel_ff;
      data_sel_in = data_sel_ff;
      ta_in       = ta_ff;
      lo_in       = lo_ff;
      pop         = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = head.addr;
      wr_data     = head.data;
      rd_addr     = {ta_ff[tfl_pkg::STORE_AW-1:1], 1'b1};
      load_out    = 1'b0;
      irq_in      = irq_ff;
      rline_in    = rline_ff;
      rgroup_in   = rgroup_ff;
      pix_in      = pix_ff;
      rlast_in    = rlast_ff;
      case (state_ff)
         tfl_pkg::ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = 8'd0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         tfl_pkg::ST_IDLE: begin
            if (head_valid) begin
               case (head.kind)
                  tfl_pkg::KIND_WRITE: begin
                     wr_en = 1'b1;
                     pop   = 1'b1;
                  end
                  tfl_pkg::KIND_VBLANK: begin
                     if (out_free) begin
                        pop       = 1'b1;
                        load_out  = 1'b1;
                        irq_in    = 1'b1;
                        rline_in  = head.line;
                        rgroup_in = '0;
                        pix_in    = 16'd0;
                        rlast_in  = 1'b1;
                     end
                  end
                  tfl_pkg::KIND_LINE: begin
                     pop         = 1'b1;
                     line_in     = head.line;
                     y_in        = head.y;
                     map_sel_in  = head.map_sel;
                     data_sel_in = head.data_sel;
                     group_in    = '0;
                     rd_addr     = tfl_pkg::map_addr(head.map_sel, head.y, '0);
                  end
                  default: pop = 1'b1;
               endcase
            end
         end
         tfl_pkg::ST_LO: begin
            // map entry arrived: look up the low plane of the tile row
            ta_in   = tfl_pkg::tile_addr(data_sel_ff, rd_data_ff, y_ff[2:0]);
            rd_addr = ta_in;
         end
         tfl_pkg::ST_HI: begin
            lo_in   = rd_data_ff;
            rd_addr = {ta_ff[tfl_pkg::STORE_AW-1:1], 1'b1};
         end
         tfl_pkg::ST_PIX: begin
            // high plane arrived; overlap the next map read with the result load
            if (out_free) begin
               load_out  = 1'b1;
               irq_in    = 1'b0;
               rline_in  = line_ff;
               rgroup_in = group_ff;
               pix_in    = tfl_pkg::interleave(lo_ff, rd_data_ff);
               rlast_in  = last_group;
               if (!last_group) begin
                  group_in = group_ff + 1'b1;
                  rd_addr  = tfl_pkg::map_addr(map_sel_ff, y_ff, group_ff + 1'b1);
               end
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
      rsp_valid_in = load_out ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tfl_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      group_ff    <= group_in;
      line_ff     <= line_in;
      y_ff        <= y_in;
      map_sel_ff  <= map_sel_in;
      data_sel_ff <= data_sel_in;
      ta_ff       <= ta_in;
      lo_ff       <= lo_in;
      irq_ff      <= irq_in;
      rline_ff    <= rline_in;
      rgroup_ff   <= rgroup_in;
      pix_ff      <= pix_in;
      rlast_ff    <= rlast_in;
   end

   // Video store write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         video_mem[wr_addr] <= wr_data;
      end
   end

   // Video store read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= video_mem[rd_addr];
   end

endmodule

FILE: test/tfl_fetch_checker.sv
// Scoreboard for the background line fetch: tracks store and registers, predicts and compares.
module tfl_fetch_checker import tfl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   tfl_req_if                req_mon,
   tfl_rsp_if                rsp_mon,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   input  logic              csr_pready,
   output int                mismatch_count,
   output int                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic               vblank_irq;
      logic [LINE_W-1:0]  line_number;
      logic [GROUP_W-1:0] group_index;
      logic [15:0]        pixels;
      logic               last;
   } pixel_group_type;

   // Shadow of the video store, line counter and registers
   logic [7:0]        vram_shadow [STORE_DEPTH];
   logic [LINE_W-1:0] line_now;
   logic [7:0]        scroll_y_q;
   logic              map_sel_q;
   logic              data_sel_q;

   pixel_group_type expected_groups [$];
   int              errors;

   // Low-plane byte of one row of a tile, in the addressing mode now selected
   function automatic logic [STORE_AW-1:0] tile_row_byte(input logic [7:0] tile,
                                                         input logic [2:0] row);
      int base;
      if (data_sel_q) begin
         base = int'(tile) * 16;
      end else begin
         base = int'(SIGNED_BASE) + int'($signed(tile)) * 16;
      end
      return STORE_AW'(base + 2 * int'(row));
   endfunction

   // Advance the line and queue the pixel groups (or vblank) it produces
   task automatic predict_line();
      logic [7:0]          y;
      logic [STORE_AW-1:0] map_base;
      logic [STORE_AW-1:0] row_addr;
      logic [7:0]          tile;
      logic [7:0]          lo;
      logic [7:0]          hi;
      pixel_group_type     res;
      line_now = (line_now == LINE_W'(TOTAL_LINES - 1)) ? '0 : line_now + 1'b1;
      if (line_now == LINE_W'(VBLANK_LINE)) begin
         res.vblank_irq  = 1'b1;
         res.line_number = line_now;
         res.group_index = '0;
         res.pixels      = '0;
         res.last        = 1'b1;
         expected_groups.push_back(res);
      end else if (line_now < LINE_W'(VBLANK_LINE)) begin
         y = line_now + scroll_y_q;
         map_base = map_sel_q ? MAP_HIGH_BASE : MAP_LOW_BASE;
         for (int g = 0; g < GROUPS; g++) begin
            tile = vram_shadow[map_base + STORE_AW'(32 * int'(y[7:3]) + (g % 32))];
            row_addr = tile_row_byte(tile, y[2:0]);
            lo = vram_shadow[row_addr];
            hi = vram_shadow[row_addr + 1'b1];
            res.vblank_irq  = 1'b0;
            res.line_number = line_now;
            res.group_index = GROUP_W'(g);
            res.pixels      = '0;
            // leftmost pixel ends up in the top two bits
            for (int b = 7; b >= 0; b--) begin
               res.pixels = {res.pixels[13:0], hi[b], lo[b]};
            end
            res.last = (g == GROUPS - 1);
            expected_groups.push_back(res);
         end
      end
   endtask

   // Compare one accepted result item with the oldest prediction
   task automatic check_group();
      pixel_group_type got;
      pixel_group_type want;
      got.vblank_irq  = rsp_mon.vblank_irq;
      got.line_number = rsp_mon.line_number;
      got.group_index = rsp_mon.group_index;
      got.pixels      = rsp_mon.pixels;
      got.last        = rsp_mon.last;
      if (expected_groups.size() == 0) begin
         errors++;
         if (errors <= 10) begin
            $display("%0t: unexpected item vblank=%0d line=%0d group=%0d pixels=%04h last=%0d",
                     $realtime, got.vblank_irq, got.line_number, got.group_index,
                     got.pixels, got.last);
         end
      end else begin
         want = expected_groups.pop_front();
         if (got.vblank_irq !== want.vblank_irq || got.line_number !== want.line_number ||
             got.group_index !== want.group_index || got.pixels !== want.pixels ||
             got.last !== want.last) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: mismatch expected vblank=%0d line=%0d group=%0d pixels=%04h last=%0d",
                        $realtime, want.vblank_irq, want.line_number, want.group_index,
                        want.pixels, want.last);
               $display("%0t:          actual vblank=%0d line=%0d group=%0d pixels=%04h last=%0d",
                        $realtime, got.vblank_irq, got.line_number, got.group_index,
                        got.pixels, got.last);
            end
         end
      end
   endtask

   // Watch register writes, input items and result items at each edge
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            vram_shadow[i] = '0;
         end
         line_now   = '0;
         scroll_y_q = '0;
         map_sel_q  = 1'b0;
         data_sel_q = 1'b1;
         expected_groups.delete();
         errors = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_AW-1:2])
               CSR_SCROLL_Y:    scroll_y_q = csr_pwdata[7:0];
               CSR_MAP_SELECT:  map_sel_q  = csr_pwdata[0];
               CSR_DATA_SELECT: data_sel_q = csr_pwdata[0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.cmd == CMD_WRITE) begin
               vram_shadow[req_mon.store_addr] = req_mon.store_data;
            end else begin
               predict_line();
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_group();
         end
      end
      mismatch_count <= errors;
      pending_count  <= expected_groups.size();
   end

endmodule

FILE: test/tile_background_line_fetch_tb.sv
// Top of the line fetch testbench: clock, reset, register setup, item stimulus and verdict.
module tile_background_line_fetch_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tfl_pkg::*;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int HOLD_CYCLES   = 600;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_CYCLES  = 40;
   localparam int PHASE_ITEMS   = 73;
   localparam int PHASES        = 6;

   logic              clock;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   int mismatches;
   int pending;
   int cycles;

   // pacing controls shared by sender and receiver
   bit steady;
   bit hold_rsp;

   // what the stimulus knows of the current setup, used to aim writes
   logic [7:0]        cur_scroll;
   logic              cur_map_sel;
   logic              cur_data_sel;
   logic [LINE_W-1:0] line_ahead;

   tfl_req_if req_bus ();
   tfl_rsp_if rsp_bus ();

   tile_background_line_fetch i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   tfl_fetch_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatches),
      .pending_count  (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one, none in steady stretches
   function automatic int pick_gap();
      int r;
      if (steady) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   // Tile numbers at the edges of both addressing modes, plus a random one
   function automatic logic [7:0] pick_tile();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return 8'h01;
         2:       return 8'h7F;
         3:       return 8'h80;
         4:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Store offset of one plane byte of a tile row
   function automatic logic [STORE_AW-1:0] tile_byte(input logic [7:0] tile, input logic signed_mode,
                                                     input logic [2:0] row, input logic plane);
      int base;
      if (signed_mode) begin
         base = int'(SIGNED_BASE) + int'($signed(tile)) * 16;
      end else begin
         base = int'(tile) * 16;
      end
      return STORE_AW'(base + 2 * int'(row) + int'(plane));
   endfunction

   // Offer one item and hold it until the block takes it
   task automatic push_item(input logic cmd, input logic [STORE_AW-1:0] addr,
                            input logic [7:0] data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= cmd;
      req_bus.store_addr <= addr;
      req_bus.store_data <= data;
      do @(posedge clock); while (!req_bus.ready);
      if (cmd == CMD_TICK) begin
         line_ahead = (line_ahead == LINE_W'(TOTAL_LINES - 1)) ? '0 : line_ahead + 1'b1;
      end
   endtask

   // Register write: setup phase, then access phase until csr_pready, then idle
   task automatic csr_write(input logic [1:0] index, input logic [CSR_DW-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setup(input logic [7:0] scroll, input logic map_sel, input logic data_sel);
      csr_write(CSR_SCROLL_Y, CSR_DW'(scroll));
      csr_write(CSR_MAP_SELECT, CSR_DW'(map_sel));
      csr_write(CSR_DATA_SELECT, CSR_DW'(data_sel));
      cur_scroll   = scroll;
      cur_map_sel  = map_sel;
      cur_data_sel = data_sel;
   endtask

   // Stop offering, wait for every predicted item, then let stray writes land
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One random item: ticks, map entries and tile rows aimed at the next line, and noise
   task automatic random_item();
      int                  r;
      logic [7:0]          y;
      logic [4:0]          row;
      logic                map_sel;
      logic [STORE_AW-1:0] addr;
      r = $urandom_range(0, 99);
      y = ((line_ahead == LINE_W'(TOTAL_LINES - 1)) ? 8'd0 : line_ahead + 8'd1) + cur_scroll;
      if (r < 48) begin
         push_item(CMD_TICK, STORE_AW'($urandom), 8'($urandom));
      end else if (r < 70) begin
         row = ($urandom_range(0, 9) < 7) ? y[7:3] : 5'($urandom);
         map_sel = ($urandom_range(0, 9) == 0) ? ~cur_map_sel : cur_map_sel;
         addr = (map_sel ? MAP_HIGH_BASE : MAP_LOW_BASE) + STORE_AW'({row, 5'($urandom)});
         push_item(CMD_WRITE, addr, pick_tile());
      end else if (r < 92) begin
         addr = tile_byte(pick_tile(),
                          ($urandom_range(0, 4) == 0) ? cur_data_sel : ~cur_data_sel,
                          ($urandom_range(0, 9) < 7) ? y[2:0] : 3'($urandom),
                          1'($urandom));
         push_item(CMD_WRITE, addr, 8'($urandom));
      end else begin
         push_item(CMD_WRITE, STORE_AW'($urandom), 8'($urandom));
      end
   endtask

   // Result side pacing, with one long hold-off on request
   initial begin : rsp_pacing
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Run limit
   initial begin : watchdog
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Stimulus and verdict
   initial begin : stimulus
      steady   = 1'b0;
      hold_rsp = 1'b0;
      line_ahead         = '0;
      cur_scroll         = '0;
      cur_map_sel        = 1'b0;
      cur_data_sel       = 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.cmd        <= CMD_WRITE;
      req_bus.store_addr <= '0;
      req_bus.store_data <= '0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= '0;
      csr_pwdata         <= '0;
      reset              <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: store extremes, tile zero, signed and unsigned edge tiles, line 1
      apply_setup(8'd0, 1'b0, 1'b1);
      push_item(CMD_WRITE, '0, 8'hFF);
      push_item(CMD_WRITE, STORE_AW'(STORE_DEPTH - 1), 8'hFF);
      push_item(CMD_WRITE, tile_byte(8'h00, 1'b0, 3'd1, 1'b0), 8'hC3);
      push_item(CMD_WRITE, tile_byte(8'h00, 1'b0, 3'd1, 1'b1), 8'h5A);
      push_item(CMD_WRITE, MAP_LOW_BASE + 13'd1, 8'hFF);
      push_item(CMD_WRITE, MAP_LOW_BASE + 13'd19, 8'h80);
      push_item(CMD_WRITE, MAP_LOW_BASE + 13'd18, 8'h7F);
      push_item(CMD_WRITE, tile_byte(8'hFF, 1'b0, 3'd1, 1'b0), 8'h0F);
      push_item(CMD_WRITE, tile_byte(8'hFF, 1'b0, 3'd1, 1'b1), 8'hF0);
      push_item(CMD_WRITE, tile_byte(8'h80, 1'b0, 3'd1, 1'b0), 8'hAA);
      push_item(CMD_WRITE, tile_byte(8'h7F, 1'b0, 3'd1, 1'b1), 8'h81);
      push_item(CMD_WRITE, tile_byte(8'h7F, 1'b1, 3'd1, 1'b0), 8'h18);
      push_item(CMD_TICK, '0, '0);

      // directed: high map, signed tiles, scroll wrapping the line
      settle();
      apply_setup(8'd255, 1'b1, 1'b0);
      push_item(CMD_WRITE, MAP_HIGH_BASE, 8'h7F);
      push_item(CMD_WRITE, MAP_HIGH_BASE + 13'd19, 8'h00);
      push_item(CMD_WRITE, tile_byte(8'h00, 1'b1, 3'd1, 1'b0), 8'hE7);
      push_item(CMD_TICK, STORE_AW'(STORE_DEPTH - 1), 8'hFF);
      push_item(CMD_TICK, '0, '0);

      // random phases, each with its own register setup
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         steady = 1'b0;
         case (phase)
            0: apply_setup(8'd0, 1'b0, 1'b1);
            1: apply_setup(8'd255, 1'b1, 1'b0);
            2: apply_setup(8'd0, 1'b1, 1'b1);
            3: apply_setup(8'($urandom), 1'b0, 1'b0);
            4: apply_setup(8'd255, 1'b0, 1'b1);
            default: apply_setup(8'($urandom), 1'b1, 1'($urandom));
         endcase
         // receiver holds off while the sender keeps the block full
         if (phase == 2) begin
            steady   = 1'b1;
            hold_rsp = 1'b1;
         end
         if (phase == 4) begin
            steady = 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            random_item();
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
